// ===== rtl/core/onb_pkg.sv =====
// Shared constants and types for the Oren-Nayar BRDF evaluator.
`default_nettype none

package onb_pkg;

    // Default number of fraction bits of the angular ratio.
    localparam int ONB_FRAC_BITS = 16;

    localparam int ONB_IN_W      = 16;
    localparam int ONB_OUT_W     = 24;
    localparam int ONB_COEFF_W   = 17;
    localparam int ONB_REFL_W    = 16;
    localparam int ONB_CFG_IDX_W = 3;
    localparam int ONB_INV_PI_W  = 31;

    // round(2^32 / pi)
    localparam logic [ONB_INV_PI_W-1:0] ONB_INV_PI_Q32 = 31'd1367130551;

    localparam logic [ONB_COEFF_W-1:0] ONB_COEFF_A_RST = 17'd65536;
    localparam logic [ONB_COEFF_W-1:0] ONB_COEFF_B_RST = 17'd0;
    localparam logic [ONB_REFL_W-1:0]  ONB_REFL_RST    = 16'd65535;

    typedef enum logic [ONB_CFG_IDX_W-1:0] {
        CFG_COEFF_A    = 3'd0,
        CFG_COEFF_B    = 3'd1,
        CFG_REFL_RED   = 3'd2,
        CFG_REFL_GREEN = 3'd3,
        CFG_REFL_BLUE  = 3'd4
    } t_cfg_idx;

endpackage

`default_nettype wire

// ===== rtl/core/oren_nayar_brdf_eval.sv =====
// Pipelined Oren-Nayar diffuse BRDF evaluator with a skid stage at the output.
//
//  channel   direction  handshake                     payload
//  request   in         i_in_valid / o_in_stall       i_incident_{x,y,z}, i_exitant_{x,y,z}
//  result    out        o_out_valid / i_out_stall     o_value_{red,green,blue}, o_saturated
//  config    in         i_cfg_we                      i_cfg_index, i_cfg_data
//
// One request is accepted every cycle while o_in_stall is low.
// The ratio divider resolves one quotient bit per stage, FRAC_BITS + 8 stages in all.
// Reset is synchronous and active low; it clears all valid bits and loads the
// register defaults. A result that meets a stalled output goes to the skid stage,
// and o_in_stall is the registered skid-full flag, so the pipeline freezes in the following cycle.
`default_nettype none

module oren_nayar_brdf_eval
    import onb_pkg::*;
#(
    parameter int FRAC_BITS = ONB_FRAC_BITS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,

    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire  signed [ONB_IN_W-1:0]       i_incident_x,
    input  wire  signed [ONB_IN_W-1:0]       i_incident_y,
    input  wire  signed [ONB_IN_W-1:0]       i_incident_z,
    input  wire  signed [ONB_IN_W-1:0]       i_exitant_x,
    input  wire  signed [ONB_IN_W-1:0]       i_exitant_y,
    input  wire  signed [ONB_IN_W-1:0]       i_exitant_z,

    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic        [ONB_OUT_W-1:0]      o_value_red,
    output logic        [ONB_OUT_W-1:0]      o_value_green,
    output logic        [ONB_OUT_W-1:0]      o_value_blue,
    output logic                             o_saturated,

    input  wire                              i_cfg_we,
    input  wire         [ONB_CFG_IDX_W-1:0]  i_cfg_index,
    input  wire         [ONB_COEFF_W-1:0]    i_cfg_data
);

    localparam int QW     = FRAC_BITS + 8;            // ratio width, also divider depth
    localparam int PB_W   = ONB_COEFF_W + QW;         // coeff_b * ratio
    localparam int SUM_W  = PB_W + 1;
    localparam int S16_W  = SUM_W - FRAC_BITS;
    localparam int PPI_W  = S16_W + ONB_INV_PI_W;     // s16 * (1/pi)
    localparam int FAC_W  = PPI_W + 1 - 32;
    localparam int PCH_W  = ONB_REFL_W + FAC_W;       // reflectance * factor
    localparam int V_W    = PCH_W + 1 - 16;
    localparam int DOT_W  = 32;
    localparam int DEN_W  = 16;

    localparam logic [PPI_W:0] PI_RND = (PPI_W + 1)'(1) << 31;
    localparam logic [PCH_W:0] CH_RND = (PCH_W + 1)'(1) << 15;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ONB_COEFF_W-1:0] r_coeff_a;
    logic [ONB_COEFF_W-1:0] r_coeff_b;
    logic [ONB_REFL_W-1:0]  r_refl_red;
    logic [ONB_REFL_W-1:0]  r_refl_green;
    logic [ONB_REFL_W-1:0]  r_refl_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff_a    <= ONB_COEFF_A_RST;
            r_coeff_b    <= ONB_COEFF_B_RST;
            r_refl_red   <= ONB_REFL_RST;
            r_refl_green <= ONB_REFL_RST;
            r_refl_blue  <= ONB_REFL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COEFF_A:    r_coeff_a    <= i_cfg_data;
                CFG_COEFF_B:    r_coeff_b    <= i_cfg_data;
                CFG_REFL_RED:   r_refl_red   <= i_cfg_data[ONB_REFL_W-1:0];
                CFG_REFL_GREEN: r_refl_green <= i_cfg_data[ONB_REFL_W-1:0];
                CFG_REFL_BLUE:  r_refl_blue  <= i_cfg_data[ONB_REFL_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance control
    // ------------------------------------------------------------------
    logic r_k_valid;
    logic r_o_valid;
    logic en;
    logic out_take;

    assign en         = !r_k_valid;
    assign out_take   = r_o_valid && !i_out_stall;
    assign o_in_stall = r_k_valid;

    // ------------------------------------------------------------------
    // Stage A: products of the tangent components and the denominator
    // ------------------------------------------------------------------
    logic signed [DOT_W-1:0] n_a_pxx, n_a_pyy;
    logic        [DEN_W-1:0] n_a_absi, n_a_abso, n_a_den;
    logic                    r_a_valid;
    logic signed [DOT_W-1:0] r_a_pxx, r_a_pyy;
    logic        [DEN_W-1:0] r_a_den;

    always_comb begin
        n_a_pxx  = DOT_W'(i_incident_x) * DOT_W'(i_exitant_x);
        n_a_pyy  = DOT_W'(i_incident_y) * DOT_W'(i_exitant_y);
        n_a_absi = i_incident_z[ONB_IN_W-1] ? DEN_W'(-i_incident_z) : DEN_W'(i_incident_z);
        n_a_abso = i_exitant_z[ONB_IN_W-1]  ? DEN_W'(-i_exitant_z)  : DEN_W'(i_exitant_z);
        n_a_den  = (n_a_absi > n_a_abso) ? n_a_absi : n_a_abso;
    end

    // ------------------------------------------------------------------
    // Stage B: clamped dot product, overflow test, divider setup
    // ------------------------------------------------------------------
    logic signed [DOT_W:0]   b_dots;
    logic        [DOT_W-1:0] n_b_dot;
    logic                    n_b_sat;

    always_comb begin
        b_dots  = (DOT_W + 1)'(r_a_pxx) + (DOT_W + 1)'(r_a_pyy);
        n_b_dot = b_dots[DOT_W] ? '0 : b_dots[DOT_W-1:0];
        // The quotient exceeds its range exactly when dot >= den * 2^23.
        // A zero denominator always lands here as well.
        n_b_sat = {7'd0, n_b_dot} >= {r_a_den, 23'd0};
    end

    // Divider stages: index 0 is loaded by stage B, each later index adds one
    // quotient bit. The partial remainder stays below den * 2^15.
    logic             r_dv_valid [0:QW];
    logic [DOT_W-1:0] r_dv_rem   [0:QW];
    logic [QW-1:0]    r_dv_quo   [0:QW];
    logic [7:0]       r_dv_low   [0:QW];
    logic [DEN_W-1:0] r_dv_den   [0:QW];
    logic             r_dv_sat   [0:QW];

    logic [DOT_W-1:0] dv_trial   [1:QW];
    logic [DOT_W-1:0] dv_divisor [1:QW];
    logic             dv_bit     [1:QW];
    logic [DOT_W-1:0] n_dv_rem   [1:QW];
    logic [QW-1:0]    n_dv_quo   [1:QW];
    logic [7:0]       n_dv_low   [1:QW];

    always_comb begin
        for (int j = 1; j <= QW; j++) begin
            dv_trial[j]   = {r_dv_rem[j-1][DOT_W-2:0], r_dv_low[j-1][7]};
            dv_divisor[j] = {1'b0, r_dv_den[j-1], 15'd0};
            dv_bit[j]     = dv_trial[j] >= dv_divisor[j];
            n_dv_rem[j]   = dv_bit[j] ? (dv_trial[j] - dv_divisor[j]) : dv_trial[j];
            n_dv_quo[j]   = {r_dv_quo[j-1][QW-2:0], dv_bit[j]};
            n_dv_low[j]   = {r_dv_low[j-1][6:0], 1'b0};
        end
    end

    // ------------------------------------------------------------------
    // Stages C..G: B * ratio, A + ..., times 1/pi, rounding, channel products
    // ------------------------------------------------------------------
    logic [QW-1:0]    c_ratio;
    logic [PB_W-1:0]  n_c_prod;
    logic [SUM_W-1:0] d_sum;
    logic [PPI_W:0]   f_sum;

    logic             r_c_valid, r_d_valid, r_e_valid, r_f_valid, r_g_valid;
    logic             r_c_sat,   r_d_sat,   r_e_sat,   r_f_sat,   r_g_sat;
    logic [PB_W-1:0]  r_c_prod;
    logic [S16_W-1:0] r_d_s16;
    logic [PPI_W-1:0] r_e_prod;
    logic [FAC_W-1:0] r_f_fac;
    logic [PCH_W-1:0] r_g_red, r_g_green, r_g_blue;

    always_comb begin
        c_ratio  = r_dv_sat[QW] ? '1 : r_dv_quo[QW];
        n_c_prod = PB_W'(r_coeff_b) * PB_W'(c_ratio);
        d_sum    = SUM_W'({r_coeff_a, {FRAC_BITS{1'b0}}}) + SUM_W'(r_c_prod);
        f_sum    = (PPI_W + 1)'(r_e_prod) + PI_RND;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            for (int j = 0; j <= QW; j++) begin
                r_dv_valid[j] <= 1'b0;
            end
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
        end else if (en) begin
            r_a_valid     <= i_in_valid;
            r_dv_valid[0] <= r_a_valid;
            for (int j = 1; j <= QW; j++) begin
                r_dv_valid[j] <= r_dv_valid[j-1];
            end
            r_c_valid <= r_dv_valid[QW];
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
            r_f_valid <= r_e_valid;
            r_g_valid <= r_f_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_pxx <= n_a_pxx;
            r_a_pyy <= n_a_pyy;
            r_a_den <= n_a_den;

            r_dv_rem[0] <= {8'd0, n_b_dot[DOT_W-1:8]};
            r_dv_quo[0] <= '0;
            r_dv_low[0] <= n_b_dot[7:0];
            r_dv_den[0] <= r_a_den;
            r_dv_sat[0] <= n_b_sat;
            for (int j = 1; j <= QW; j++) begin
                r_dv_rem[j] <= n_dv_rem[j];
                r_dv_quo[j] <= n_dv_quo[j];
                r_dv_low[j] <= n_dv_low[j];
                r_dv_den[j] <= r_dv_den[j-1];
                r_dv_sat[j] <= r_dv_sat[j-1];
            end

            r_c_prod  <= n_c_prod;
            r_c_sat   <= r_dv_sat[QW];
            r_d_s16   <= d_sum[SUM_W-1:FRAC_BITS];
            r_d_sat   <= r_c_sat;
            r_e_prod  <= PPI_W'(r_d_s16) * PPI_W'(ONB_INV_PI_Q32);
            r_e_sat   <= r_d_sat;
            r_f_fac   <= f_sum[PPI_W:32];
            r_f_sat   <= r_e_sat;
            r_g_red   <= PCH_W'(r_refl_red)   * PCH_W'(r_f_fac);
            r_g_green <= PCH_W'(r_refl_green) * PCH_W'(r_f_fac);
            r_g_blue  <= PCH_W'(r_refl_blue)  * PCH_W'(r_f_fac);
            r_g_sat   <= r_f_sat;
        end
    end

    // ------------------------------------------------------------------
    // Final rounding and clamp, output register and skid stage
    // ------------------------------------------------------------------
    function automatic logic [ONB_OUT_W:0] f_chan(input logic [PCH_W-1:0] p);
        logic [PCH_W:0] s;
        logic [V_W-1:0] v;
        s = (PCH_W + 1)'(p) + CH_RND;
        v = s[PCH_W:16];
        if (|v[V_W-1:ONB_OUT_W]) begin
            f_chan = {1'b1, {ONB_OUT_W{1'b1}}};
        end else begin
            f_chan = {1'b0, v[ONB_OUT_W-1:0]};
        end
    endfunction

    logic [ONB_OUT_W:0]   fin_red, fin_green, fin_blue;
    logic                 fin_sat;

    always_comb begin
        fin_red   = f_chan(r_g_red);
        fin_green = f_chan(r_g_green);
        fin_blue  = f_chan(r_g_blue);
        fin_sat   = r_g_sat | fin_red[ONB_OUT_W] | fin_green[ONB_OUT_W] | fin_blue[ONB_OUT_W];
    end

    logic [ONB_OUT_W-1:0] r_o_red, r_o_green, r_o_blue;
    logic                 r_o_sat;
    logic [ONB_OUT_W-1:0] r_k_red, r_k_green, r_k_blue;
    logic                 r_k_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_k_valid <= 1'b0;
        end else if (r_k_valid) begin
            if (out_take) begin
                r_k_valid <= 1'b0;
            end
        end else if (r_g_valid) begin
            if (!r_o_valid || out_take) begin
                r_o_valid <= 1'b1;
            end else begin
                r_k_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_k_valid) begin
            if (out_take) begin
                r_o_red   <= r_k_red;
                r_o_green <= r_k_green;
                r_o_blue  <= r_k_blue;
                r_o_sat   <= r_k_sat;
            end
        end else if (r_g_valid) begin
            if (!r_o_valid || out_take) begin
                r_o_red   <= fin_red[ONB_OUT_W-1:0];
                r_o_green <= fin_green[ONB_OUT_W-1:0];
                r_o_blue  <= fin_blue[ONB_OUT_W-1:0];
                r_o_sat   <= fin_sat;
            end else begin
                r_k_red   <= fin_red[ONB_OUT_W-1:0];
                r_k_green <= fin_green[ONB_OUT_W-1:0];
                r_k_blue  <= fin_blue[ONB_OUT_W-1:0];
                r_k_sat   <= fin_sat;
            end
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_value_red   = r_o_red;
    assign o_value_green = r_o_green;
    assign o_value_blue  = r_o_blue;
    assign o_saturated   = r_o_sat;

`ifndef SYNTHESIS
    // The skid stage only ever holds a result behind a waiting output.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k_valid |-> r_o_valid)
        else $error("skid stage full while output register is empty");

    // The skid stage fills only after the output was stalled.
    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_k_valid) |-> $past(r_o_valid && i_out_stall))
        else $error("skid stage filled without an output stall");

    // Without overflow the partial remainder must end below the divisor.
    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv_valid[QW] && !r_dv_sat[QW]) |->
            (r_dv_rem[QW] < {1'b0, r_dv_den[QW], 15'd0}))
        else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire
